// ----- rtl/core/pasi_pkg.sv -----
// Package for the periodic alarm sorted insert core.
// Holds table depth default, datapath widths and controller/datapath command and status types.
package pasi_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned TimeW = 64;
  localparam int unsigned IdW = 4;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic set_due;
    logic scan_start;
    logic scan_step;
    logic shift_step;
    logic commit;
    logic emit;
    logic emit_full;
  } pasi_cmd_t;

  typedef struct packed {
    logic periodic;
    logic behind;
    logic div_last;
    logic mul_last;
    logic full;
    logic scan_done;
    logic shift_done;
  } pasi_sts_t;

endpackage

// ----- rtl/core/pasi_ctrl.sv -----
// Controller state machine for the periodic alarm sorted insert core.
// Depends on pasi_pkg for the command and status structs.
module pasi_ctrl import pasi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  pasi_sts_t sts_i,
  output pasi_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StShift = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.periodic && sts_i.behind) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          cmd_o.set_due = 1'b1;
          state_d = StScan;
          cmd_o.scan_start = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.mul_start = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.scan_start = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.full) begin
          cmd_o.emit_full = 1'b1;
          state_d = StIdle;
        end else if (sts_i.scan_done) begin
          state_d = StShift;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StShift: begin
        if (sts_i.shift_done) begin
          cmd_o.commit = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ----- rtl/core/pasi_dp.sv -----
// Datapath for the periodic alarm sorted insert core: divider, multiplier, table.
// Depends on pasi_pkg; commanded by pasi_ctrl.
module pasi_dp import pasi_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pasi_cmd_t        cmd_i,
  output pasi_sts_t        sts_o,
  input  logic [IdW-1:0]   entry_id_i,
  input  logic [TimeW-1:0] requested_due_i,
  input  logic [TimeW-1:0] interval_i,
  input  logic [TimeW-1:0] start_stamp_i,
  input  logic [TimeW-1:0] now_time_i,
  output logic             done_o,
  output logic [TimeW-1:0] due_time_o,
  output logic [IdW-1:0]   slot_o,
  output logic             became_head_o,
  output logic             status_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned StepW = $clog2(TimeW);

  logic [TimeW-1:0] due_mem [TableDepth];
  logic [IdW-1:0]   id_mem [TableDepth];

  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] req_q, ivl_q, start_q, now_q;
  logic [TimeW-1:0] rem_q, quo_q, acc_q, mcand_q;
  logic [StepW-1:0] step_q;
  logic [TimeW-1:0] due_q;
  logic [CntW-1:0]  count_q, pos_q, idx_q;
  logic             scan_done_q;
  logic [TimeW-1:0] rd_q;
  logic             rd_vld_q;

  logic [TimeW:0]   rem_sh;
  logic             quo_bit;
  logic [TimeW-1:0] quo_nxt;
  logic [TimeW-1:0] diff;

  assign rem_sh = {rem_q, quo_q[TimeW-1]};
  assign quo_bit = (rem_sh >= {1'b0, ivl_q});
  assign quo_nxt = {quo_q[TimeW-2:0], quo_bit};
  assign diff = due_q - rd_q;

  assign sts_o.periodic = (ivl_q != '0);
  assign sts_o.behind = (start_q < now_q);
  assign sts_o.div_last = (step_q == StepW'(TimeW - 1));
  assign sts_o.mul_last = (step_q == StepW'(TimeW - 1));
  assign sts_o.full = (count_q == CntW'(TableDepth));
  assign sts_o.scan_done = scan_done_q;
  assign sts_o.shift_done = (idx_q == pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q <= entry_id_i;
      req_q <= requested_due_i;
      ivl_q <= interval_i;
      start_q <= start_stamp_i;
      now_q <= now_time_i;
    end
    if (cmd_i.div_start || cmd_i.mul_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step || cmd_i.mul_step) begin
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= now_q - start_q;
    end else if (cmd_i.div_step) begin
      if (quo_bit) begin
        rem_q <= TimeW'(rem_sh - {1'b0, ivl_q});
      end else begin
        rem_q <= rem_sh[TimeW-1:0];
      end
      quo_q <= quo_nxt;
    end
    if (cmd_i.mul_start) begin
      mcand_q <= quo_nxt + 1'b1;
      acc_q <= start_q;
    end else if (cmd_i.mul_step) begin
      if (mcand_q[0]) acc_q <= acc_q + (ivl_q << step_q);
      mcand_q <= mcand_q >> 1;
      if (step_q == StepW'(TimeW - 1)) due_q <= (mcand_q[0]) ?
          acc_q + (ivl_q << step_q) : acc_q;
    end
    if (cmd_i.set_due) due_q <= sts_o.periodic ? start_q : req_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q <= '0;
      idx_q <= '0;
      scan_done_q <= 1'b0;
      rd_vld_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.emit || cmd_i.emit_full;
      if (cmd_i.scan_start) begin
        idx_q <= '0;
        pos_q <= count_q;
        scan_done_q <= (count_q == '0);
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_vld_q <= 1'b0;
        if (rd_vld_q) begin
          if (diff[TimeW-1]) begin
            pos_q <= idx_q;
            scan_done_q <= 1'b1;
            idx_q <= count_q;
          end else if (idx_q + 1'b1 == count_q) begin
            scan_done_q <= 1'b1;
            idx_q <= count_q;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end else begin
          rd_vld_q <= 1'b1;
        end
      end else if (cmd_i.shift_step) begin
        idx_q <= idx_q - 1'b1;
      end
      if (cmd_i.commit) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= due_mem[idx_q[IdxW-1:0]];
    if (cmd_i.shift_step) begin
      due_mem[idx_q[IdxW-1:0]] <= due_mem[idx_q[IdxW-1:0] - 1'b1];
      id_mem[idx_q[IdxW-1:0]] <= id_mem[idx_q[IdxW-1:0] - 1'b1];
    end
    if (cmd_i.commit) begin
      due_mem[pos_q[IdxW-1:0]] <= due_q;
      id_mem[pos_q[IdxW-1:0]] <= id_q;
    end
    if (cmd_i.emit || cmd_i.emit_full) begin
      due_time_o <= due_q;
      slot_o <= cmd_i.emit_full ? '0 : IdW'(pos_q);
      became_head_o <= cmd_i.emit && (pos_q == '0);
      status_o <= cmd_i.emit_full;
    end
  end

endmodule

// ----- rtl/core/periodic_alarm_sorted_insert_core.sv -----
// Top level of the periodic alarm sorted insert core.
// Instantiates pasi_ctrl and pasi_dp; depends on pasi_pkg.
//
// Channel  Direction  Handshake       Fields
// request  in         start & !busy   entry_id, requested_due, interval, start_stamp, now_time
// result   out        done_o strobe   due_time, slot, became_head, status
//
// busy stays high while stored entries are compared and shifted; a full table
// ends the request without an insert and sets status. A periodic roll-forward
// adds a bit-serial divide and a shift-add multiply.
// done_o pulses in the first cycle after busy falls. Reset empties the table at once.
// The result strobe lasts one cycle; the receiver cannot stall it.
module periodic_alarm_sorted_insert_core import pasi_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IdW-1:0]   entry_id_i,
  input  logic [TimeW-1:0] requested_due_i,
  input  logic [TimeW-1:0] interval_i,
  input  logic [TimeW-1:0] start_stamp_i,
  input  logic [TimeW-1:0] now_time_i,
  output logic             done_o,
  output logic [TimeW-1:0] due_time_o,
  output logic [IdW-1:0]   slot_o,
  output logic             became_head_o,
  output logic             status_o
);

  pasi_cmd_t cmd;
  pasi_sts_t sts;

  pasi_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .busy_o(busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  pasi_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_id_i     (entry_id_i),
    .requested_due_i(requested_due_i),
    .interval_i     (interval_i),
    .start_stamp_i  (start_stamp_i),
    .now_time_i     (now_time_i),
    .done_o         (done_o),
    .due_time_o     (due_time_o),
    .slot_o         (slot_o),
    .became_head_o  (became_head_o),
    .status_o       (status_o)
  );

endmodule
